@@ rtl/core/uthb_pkg.sv @@
// Shared types and constants for the 8N2 UART transmitter with holding buffer.
// No dependencies; every other file in rtl/core imports this package.

package uthb_pkg;

  localparam int DATA_W  = 8;
  localparam int PHASE_W = 4;

  typedef logic [PHASE_W-1:0] phase_t;

  // Bit phase: idle, data bits 0..7, two stop bits, then end of frame.
  localparam phase_t PHASE_IDLE       = 4'd0;
  localparam phase_t PHASE_FIRST_DATA = 4'd1;
  localparam phase_t PHASE_LAST_DATA  = 4'd8;
  localparam phase_t PHASE_STOP_A     = 4'd9;
  localparam phase_t PHASE_STOP_B     = 4'd10;

  // Item command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic LINE_IDLE  = 1'b1;
  localparam logic LINE_START = 1'b0;
  localparam logic LINE_STOP  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic line_level;
    logic holding_full;
    logic busy_res;
  } result_t;

endpackage

@@ rtl/core/uthb_if.sv @@
// Valid/ready channel interfaces for the UART transmitter item and result streams.
// Depends on uthb_pkg for payload widths.

interface uthb_in_if
  import uthb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [DATA_W-1:0] data;

  modport source (output valid, output command, output data, input ready);
  modport sink   (input valid, input command, input data, output ready);
endinterface

interface uthb_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic line_level;
  logic holding_full;
  logic busy_res;

  modport source (output valid, output accepted, output line_level,
                  output holding_full, output busy_res, input ready);
  modport sink   (input valid, input accepted, input line_level,
                  input holding_full, input busy_res, output ready);
endinterface

@@ rtl/core/uart_tx_8n2_holding_buffer_unit.sv @@
// Top level of the 8N2 UART transmitter with a one-byte holding buffer.
// Depends on uthb_pkg, uthb_if, uthb_in_stage, uthb_core and uthb_out_stage.
//
//   channel  direction  handshake           payload
//   in_ch    sink       valid/ready         command, data
//   out_ch   source     valid/ready         accepted, line_level, holding_full, busy_res
//
// One item is taken per cycle while out_ch does not stall; the item is held in the input
// register, passes the state update, and its result is held in the result register,
// which presents it on out_ch until it transfers.
// Reset (rst_n low, synchronous) empties both stages, idles the phase, clears the
// buffer flag and drives the line high. A stall on out_ch holds the result; the
// held input item then waits and in_ch.ready drops once the input stage is full.

module uart_tx_8n2_holding_buffer_unit
  import uthb_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  uthb_in_if.sink     in_ch,
  uthb_out_if.source  out_ch
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  result_t res_nxt;
  result_t res_q;

  assign in_item.command = in_ch.command;
  assign in_item.data    = in_ch.data;

  // Process the held item whenever the result register can take its result.
  assign advance = item_valid && out_free;

  uthb_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // State advances only on an item that moves into the result register.
  uthb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res_nxt)
  );

  uthb_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (res_nxt),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_out   (res_q)
  );

  assign out_ch.accepted     = res_q.accepted;
  assign out_ch.line_level   = res_q.line_level;
  assign out_ch.holding_full = res_q.holding_full;
  assign out_ch.busy_res     = res_q.busy_res;

endmodule

@@ rtl/core/uthb_in_stage.sv @@
// Input register stage: captures one item per transfer and holds it until processed.
// Depends on uthb_pkg.

module uthb_in_stage
  import uthb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  // Refill in the same cycle the held item moves on.
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/uthb_core.sv @@
// Transmitter state and next-state logic: phase, shift register, holding buffer, line.
// Depends on uthb_pkg.

module uthb_core
  import uthb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  phase_t            bit_phase_r, bit_phase_nxt;
  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic [DATA_W-1:0] hold_byte_r, hold_byte_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  logic              tx_line_r, tx_line_nxt;
  logic              accepted;

  always_comb begin
    bit_phase_nxt  = bit_phase_r;
    shift_nxt      = shift_r;
    hold_byte_nxt  = hold_byte_r;
    hold_valid_nxt = hold_valid_r;
    tx_line_nxt    = tx_line_r;
    accepted       = 1'b0;

    if (item.command == CMD_WRITE) begin
      // Refuse when the buffer is full; otherwise store, and start if idle.
      if (!hold_valid_r) begin
        accepted = 1'b1;
        if (bit_phase_r == PHASE_IDLE) begin
          shift_nxt     = item.data;
          tx_line_nxt   = LINE_START;
          bit_phase_nxt = PHASE_FIRST_DATA;
        end else begin
          hold_byte_nxt  = item.data;
          hold_valid_nxt = 1'b1;
        end
      end
    end else begin
      case (bit_phase_r) inside
        PHASE_IDLE: begin
        end
        [PHASE_FIRST_DATA:PHASE_LAST_DATA]: begin
          tx_line_nxt   = shift_r[0];
          shift_nxt     = shift_r >> 1;
          bit_phase_nxt = bit_phase_r + phase_t'(1);
        end
        PHASE_STOP_A, PHASE_STOP_B: begin
          tx_line_nxt   = LINE_STOP;
          bit_phase_nxt = bit_phase_r + phase_t'(1);
        end
        default: begin
          // End of frame, also for the unused phases.
          if (hold_valid_r) begin
            shift_nxt      = hold_byte_r;
            hold_valid_nxt = 1'b0;
            tx_line_nxt    = LINE_START;
            bit_phase_nxt  = PHASE_FIRST_DATA;
          end else begin
            bit_phase_nxt = PHASE_IDLE;
          end
        end
      endcase
    end

    res.accepted     = accepted;
    res.line_level   = tx_line_nxt;
    res.holding_full = hold_valid_nxt;
    res.busy_res     = (bit_phase_nxt != PHASE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_phase_r  <= PHASE_IDLE;
      shift_r      <= '0;
      hold_valid_r <= 1'b0;
      tx_line_r    <= LINE_IDLE;
    end else if (advance) begin
      bit_phase_r  <= bit_phase_nxt;
      shift_r      <= shift_nxt;
      hold_valid_r <= hold_valid_nxt;
      tx_line_r    <= tx_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hold_byte_r <= hold_byte_nxt;
    end
  end

endmodule

@@ rtl/core/uthb_out_stage.sv @@
// Result register stage: holds one result until the downstream transfer completes.
// Depends on uthb_pkg.

module uthb_out_stage
  import uthb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    valid_r;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the 8N2 UART transmitter with a one-byte holding buffer.
// Depends on uthb_pkg, uthb_if and the uart_tx_8n2_holding_buffer_unit top level.

module tb;
  import uthb_pkg::*;

  // One queued stimulus entry: the item itself plus a flag that makes the
  // sender hold off until every predicted result has been checked.
  typedef struct packed {
    logic  drain;
    item_t item;
  } send_req_t;

  logic clk;
  logic rst_n;

  uthb_in_if  in_ch ();
  uthb_out_if out_ch ();

  uart_tx_8n2_holding_buffer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  send_req_t tx_requests[$];        // items still to be offered to the block
  result_t   line_results_due[$];   // predicted results, oldest first
  int        transfers_done;
  int        total_items;
  int        error_count;

  // Predicted transmitter state.
  phase_t            m_phase;
  logic [DATA_W-1:0] m_shift;
  logic [DATA_W-1:0] m_hold_byte;
  logic              m_hold_full;
  logic              m_line;

  // Move the pending byte into the shift register and drive the start bit.
  function automatic void start_frame();
    m_shift     = m_hold_byte;
    m_hold_full = 1'b0;
    m_line      = LINE_START;
    m_phase     = PHASE_FIRST_DATA;
  endfunction

  // Advance the predicted transmitter by one item and return its result.
  function automatic result_t tx_model_step(item_t it);
    result_t r;
    r.accepted = 1'b0;
    if (it.command == CMD_WRITE) begin
      // Refuse the write while a byte is already waiting.
      if (!m_hold_full) begin
        m_hold_byte = it.data;
        m_hold_full = 1'b1;
        r.accepted  = 1'b1;
        if (m_phase == PHASE_IDLE) start_frame();
      end
    end else if (m_phase != PHASE_IDLE) begin
      if (m_phase <= PHASE_LAST_DATA) begin
        // Shift out the next data bit, LSB first.
        m_line  = m_shift[0];
        m_shift = m_shift >> 1;
        m_phase = m_phase + 1'b1;
      end else if (m_phase == PHASE_STOP_A || m_phase == PHASE_STOP_B) begin
        m_line  = LINE_STOP;
        m_phase = m_phase + 1'b1;
      end else if (m_hold_full) begin
        // End of frame with a byte waiting: chain straight into the next frame.
        start_frame();
      end else begin
        m_phase = PHASE_IDLE;
      end
    end
    r.line_level   = m_line;
    r.holding_full = m_hold_full;
    r.busy_res     = (m_phase != PHASE_IDLE);
    return r;
  endfunction

  task automatic queue_item(logic cmd, logic [DATA_W-1:0] value, logic drain);
    send_req_t req;
    req.drain        = drain;
    req.item.command = cmd;
    req.item.data    = value;
    tx_requests.push_back(req);
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_item(CMD_TICK, DATA_W'($urandom_range(0, 255)), 1'b0);
  endtask

  // Driver: offer queued items on in_ch, with a random gap after each transfer.
  // Run bursts with no gap now and then so back-to-back transfers also occur.
  int send_gap;
  bit send_burst;

  always @(posedge clk) begin : drive_items
    send_req_t req;
    item_t     taken;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      // Predict the result of the item that transfers at this edge.
      if (in_ch.valid && in_ch.ready) begin
        taken.command = in_ch.command;
        taken.data    = in_ch.data;
        line_results_due.push_back(tx_model_step(taken));
        transfers_done++;
      end
      // Load the next item only once the current one has transferred.
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (tx_requests.size() == 0 ||
                     (tx_requests[0].drain && line_results_due.size() != 0)) begin
          // Hold off: nothing left, or wait for the result stream to drain.
          in_ch.valid <= 1'b0;
        end else begin
          req = tx_requests.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.command <= req.item.command;
          in_ch.data    <= req.item.data;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 9);
        end
      end
    end
  end

  // Monitor: take results on out_ch with random stalls and check each field
  // against the oldest prediction.
  int  take_gap;
  bit  take_burst;

  always @(posedge clk) begin : check_results
    result_t want;
    int      draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (line_results_due.size() == 0) begin
          $error("result transfer with no prediction waiting");
          error_count++;
        end else begin
          want = line_results_due.pop_front();
          if (out_ch.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, out_ch.accepted);
            error_count++;
          end
          if (out_ch.line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, out_ch.line_level);
            error_count++;
          end
          if (out_ch.holding_full !== want.holding_full) begin
            $error("holding_full: expected %0b, got %0b",
                   want.holding_full, out_ch.holding_full);
            error_count++;
          end
          if (out_ch.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_ch.busy_res);
            error_count++;
          end
        end
        // Draw the stall before the next result.
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        draw = take_burst ? 0 : $urandom_range(0, 9);
        out_ch.ready <= (draw == 0);
        take_gap     <= draw;
      end else if (take_gap != 0) begin
        take_gap     <= take_gap - 1;
        out_ch.ready <= (take_gap == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run
    bit first_frame;
    // Drive every input to a known value before the first edge.
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_TICK;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    transfers_done = 0;
    error_count    = 0;
    send_burst     = 1'b0;
    take_burst     = 1'b0;

    // Reset state of the prediction: idle, line high, buffer empty.
    m_phase     = PHASE_IDLE;
    m_shift     = '0;
    m_hold_byte = '0;
    m_hold_full = 1'b0;
    m_line      = LINE_IDLE;

    // Directed part.
    queue_item(CMD_TICK,  8'h00, 1'b0);   // tick while idle changes nothing
    queue_item(CMD_WRITE, 8'h00, 1'b0);   // write on an idle line starts a frame
    queue_item(CMD_WRITE, 8'hFF, 1'b0);   // write during a frame fills the buffer
    queue_item(CMD_WRITE, 8'h5A, 1'b0);   // write with the buffer full is refused
    queue_ticks(11);                      // send the all-zero frame, chain into 0xFF
    queue_ticks(11);                      // send the all-ones frame, then go idle
    queue_item(CMD_TICK,  8'hFF, 1'b0);   // idle again

    // Random part: mostly well-formed frames with random bytes and a few
    // writes landing on every phase; the rest is loose noise.
    first_frame = 1'b1;
    while (tx_requests.size() < 1040) begin
      if ($urandom_range(0, 4) != 0) begin
        // Drain before the first random frame so the pause happens at least once.
        queue_item(CMD_WRITE, DATA_W'($urandom_range(0, 255)),
                   first_frame || ($urandom_range(0, 99) == 0));
        first_frame = 1'b0;
        if ($urandom_range(0, 1) != 0)
          queue_item(CMD_WRITE, DATA_W'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(8, 26)) begin
          if ($urandom_range(0, 9) == 0)
            queue_item(CMD_WRITE, DATA_W'($urandom_range(0, 255)), 1'b0);
          else
            queue_ticks(1);
        end
      end else begin
        repeat ($urandom_range(1, 5))
          queue_item(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_TICK,
                     DATA_W'($urandom_range(0, 255)), 1'b0);
      end
    end
    total_items = tx_requests.size();

    // Hold reset, then release it for good.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to transfer and every result to be checked.
    while (transfers_done != total_items) @(posedge clk);
    while (line_results_due.size() != 0) @(posedge clk);
    // Wait on so that any stray result can still show up.
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
